### design/assert_macros.svh
// Assertion shorthands used by box_overlap_ratio.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box_overlap_ratio: implication check failed");

// Consequent expected a fixed number of cycles after the antecedent.
`define ASSERT_LATER(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("box_overlap_ratio: latency check failed");

`endif

### design/bor_pkg.sv
package bor_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 16;
  localparam int EDGE_BITS    = COORD_BITS + 1;
  localparam int AREA_BITS    = 2 * COORD_BITS;
  localparam int UNI_BITS     = AREA_BITS + 1;
  localparam int RATIO_BITS   = FRAC_BITS + 1;
  localparam int DIV_STAGES   = FRAC_BITS + 1;
  localparam int CFG_IDX_BITS = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // front stages plus queue hand-over plus divider stages plus output register
  localparam int LATENCY = DIV_STAGES + 5;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_REF_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_W = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_H = CFG_IDX_BITS'(3);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } bor_box_t;

  // item handed from the front to the back
  typedef struct packed {
    logic [AREA_BITS-1:0] inter;
    logic [UNI_BITS-1:0]  uni;
    logic                 empty;
    logic                 last;
  } bor_item_t;

  // one stage of the divider pipeline
  typedef struct packed {
    logic                  valid;
    logic [UNI_BITS-1:0]   rem;
    logic [UNI_BITS-1:0]   uni;
    logic [RATIO_BITS-1:0] quo;
    logic                  empty;
    logic                  last;
  } bor_div_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [UNI_BITS:0] div_step(input logic [UNI_BITS-1:0] rem,
                                                 input logic [UNI_BITS-1:0] uni,
                                                 input logic din);
    logic [UNI_BITS:0] trial;
    logic [UNI_BITS:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, uni};
    if (trial >= {1'b0, uni}) begin
      return {1'b1, diff[UNI_BITS-1:0]};
    end else begin
      return {1'b0, trial[UNI_BITS-1:0]};
    end
  endfunction

endpackage

### design/box_overlap_ratio.sv
// channel   dir  handshake              payload
// window    in   start && !busy         win_x, win_y, win_w, win_h, last_in
// result    out  done (one cycle)       overlap_ratio, empty_union, last_out
// config    in   cfg_we                 cfg_index, cfg_data
//
// One window per cycle; once taken, a window passes the front stages, the queue,
// the one-bit-per-stage divider and the output register to become a result.
// Three front stages (capture, extents, products) feed a two-entry queue that
// the divider drains every cycle, so the queue never fills and busy stays low.
// rst is synchronous: it clears the reference box to zero and drops all items.
// Results cannot be held off; done marks each for exactly one cycle.
`include "assert_macros.svh"

module box_overlap_ratio (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [bor_pkg::COORD_BITS-1:0]   win_x,
  input  logic [bor_pkg::COORD_BITS-1:0]   win_y,
  input  logic [bor_pkg::COORD_BITS-1:0]   win_w,
  input  logic [bor_pkg::COORD_BITS-1:0]   win_h,
  input  logic                             last_in,
  input  logic                             cfg_we,
  input  logic [bor_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bor_pkg::COORD_BITS-1:0]   cfg_data,
  output logic                             done,
  output logic [bor_pkg::RATIO_BITS-1:0]   overlap_ratio,
  output logic                             empty_union,
  output logic                             last_out
);

  bor_pkg::bor_box_t  ref_box;
  bor_pkg::bor_item_t front_item;
  bor_pkg::bor_item_t queue_item;
  logic               push;
  logic               q_full;
  logic               q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_box <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bor_pkg::REG_REF_X: ref_box.x <= cfg_data;
        bor_pkg::REG_REF_Y: ref_box.y <= cfg_data;
        bor_pkg::REG_REF_W: ref_box.w <= cfg_data;
        bor_pkg::REG_REF_H: ref_box.h <= cfg_data;
      endcase
    end
  end

  assign busy = q_full;

  bor_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (!q_full),
    .accept  (start && !busy),
    .win_x   (win_x),
    .win_y   (win_y),
    .win_w   (win_w),
    .win_h   (win_h),
    .last_in (last_in),
    .ref_box (ref_box),
    .push    (push),
    .item    (front_item)
  );

  bor_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .pop   (q_valid),
    .full  (q_full),
    .valid (q_valid),
    .dout  (queue_item)
  );

  bor_back u_back (
    .clk           (clk),
    .rst           (rst),
    .valid         (q_valid),
    .item          (queue_item),
    .done          (done),
    .overlap_ratio (overlap_ratio),
    .empty_union   (empty_union),
    .last_out      (last_out)
  );

  `ASSERT_IMPLIES(a_empty_gives_zero, done && empty_union, overlap_ratio == '0)
  `ASSERT_IMPLIES(a_ratio_in_range, done, overlap_ratio <= bor_pkg::RATIO_ONE)
  `ASSERT_LATER(a_fixed_latency, start && !busy, bor_pkg::LATENCY, done)

endmodule

### design/bor_front.sv
module bor_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          accept,
  input  logic [bor_pkg::COORD_BITS-1:0] win_x,
  input  logic [bor_pkg::COORD_BITS-1:0] win_y,
  input  logic [bor_pkg::COORD_BITS-1:0] win_w,
  input  logic [bor_pkg::COORD_BITS-1:0] win_h,
  input  logic                          last_in,
  input  bor_pkg::bor_box_t             ref_box,
  output logic                          push,
  output bor_pkg::bor_item_t            item
);

  // stage 1: captured window
  logic                   v1;
  bor_pkg::bor_box_t      win1;
  logic                   last1;

  // stage 2: overlap extents
  logic                           v2;
  logic [bor_pkg::COORD_BITS-1:0] cols2;
  logic [bor_pkg::COORD_BITS-1:0] rows2;
  logic [bor_pkg::COORD_BITS-1:0] ww2;
  logic [bor_pkg::COORD_BITS-1:0] wh2;
  logic                           apart2;
  logic                           last2;

  // stage 3: areas
  logic                          v3;
  logic [bor_pkg::AREA_BITS-1:0] inter3;
  logic [bor_pkg::AREA_BITS-1:0] area_r3;
  logic [bor_pkg::AREA_BITS-1:0] area_w3;
  logic                          apart3;
  logic                          last3;

  logic [bor_pkg::EDGE_BITS-1:0] w_right, w_bottom, r_right, r_bottom;
  logic [bor_pkg::EDGE_BITS-1:0] min_right, min_bottom, max_left, max_top;
  logic [bor_pkg::EDGE_BITS-1:0] cols_full, rows_full;
  logic                          apart;
  logic [bor_pkg::UNI_BITS-1:0]  uni_sum;
  logic                          uni_zero;

  always_comb begin
    w_right  = bor_pkg::EDGE_BITS'(win1.x) + bor_pkg::EDGE_BITS'(win1.w);
    w_bottom = bor_pkg::EDGE_BITS'(win1.y) + bor_pkg::EDGE_BITS'(win1.h);
    r_right  = bor_pkg::EDGE_BITS'(ref_box.x) + bor_pkg::EDGE_BITS'(ref_box.w);
    r_bottom = bor_pkg::EDGE_BITS'(ref_box.y) + bor_pkg::EDGE_BITS'(ref_box.h);
    apart = (bor_pkg::EDGE_BITS'(ref_box.x) > w_right) ||
            (bor_pkg::EDGE_BITS'(ref_box.y) > w_bottom) ||
            (r_right < bor_pkg::EDGE_BITS'(win1.x)) ||
            (r_bottom < bor_pkg::EDGE_BITS'(win1.y));
    min_right  = (r_right < w_right) ? r_right : w_right;
    min_bottom = (r_bottom < w_bottom) ? r_bottom : w_bottom;
    max_left   = (ref_box.x > win1.x) ? bor_pkg::EDGE_BITS'(ref_box.x)
                                      : bor_pkg::EDGE_BITS'(win1.x);
    max_top    = (ref_box.y > win1.y) ? bor_pkg::EDGE_BITS'(ref_box.y)
                                      : bor_pkg::EDGE_BITS'(win1.y);
    // extents are bounded by either box's size once the boxes meet
    cols_full = min_right - max_left;
    rows_full = min_bottom - max_top;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (accept) begin
        win1  <= '{x: win_x, y: win_y, w: win_w, h: win_h};
        last1 <= last_in;
      end
      cols2   <= cols_full[bor_pkg::COORD_BITS-1:0];
      rows2   <= rows_full[bor_pkg::COORD_BITS-1:0];
      ww2     <= win1.w;
      wh2     <= win1.h;
      apart2  <= apart;
      last2   <= last1;
      inter3  <= bor_pkg::AREA_BITS'(cols2) * bor_pkg::AREA_BITS'(rows2);
      area_w3 <= bor_pkg::AREA_BITS'(ww2) * bor_pkg::AREA_BITS'(wh2);
      area_r3 <= bor_pkg::AREA_BITS'(ref_box.w) * bor_pkg::AREA_BITS'(ref_box.h);
      apart3  <= apart2;
      last3   <= last2;
    end
  end

  // classify: apart or empty items go to the divider as 0 / 1
  always_comb begin
    uni_sum  = bor_pkg::UNI_BITS'(area_r3) + bor_pkg::UNI_BITS'(area_w3)
             - bor_pkg::UNI_BITS'(inter3);
    uni_zero = (uni_sum == '0);
    item.inter = (apart3 || uni_zero) ? '0 : inter3;
    item.uni   = (apart3 || uni_zero) ? bor_pkg::UNI_BITS'(1) : uni_sum;
    item.empty = !apart3 && uni_zero;
    item.last  = last3;
    push       = v3 && en;
  end

endmodule

### design/bor_queue.sv
module bor_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bor_pkg::bor_item_t din,
  input  logic               pop,
  output logic               full,
  output logic               valid,
  output bor_pkg::bor_item_t dout
);

  bor_pkg::bor_item_t               mem [bor_pkg::QUEUE_DEPTH];
  logic [bor_pkg::QPTR_BITS-1:0]    wr_ptr;
  logic [bor_pkg::QPTR_BITS-1:0]    rd_ptr;
  logic [bor_pkg::QCNT_BITS-1:0]    count;
  logic                             do_pop;

  assign full   = (count == bor_pkg::QCNT_BITS'(bor_pkg::QUEUE_DEPTH));
  assign valid  = (count != '0);
  assign dout   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == bor_pkg::QPTR_BITS'(bor_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == bor_pkg::QPTR_BITS'(bor_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/bor_back.sv
module bor_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  input  bor_pkg::bor_item_t             item,
  output logic                           done,
  output logic [bor_pkg::RATIO_BITS-1:0] overlap_ratio,
  output logic                           empty_union,
  output logic                           last_out
);

  localparam int LAST_STAGE = bor_pkg::DIV_STAGES - 1;

  bor_pkg::bor_div_t          st  [bor_pkg::DIV_STAGES];
  bor_pkg::bor_div_t          nxt [bor_pkg::DIV_STAGES];
  logic [bor_pkg::UNI_BITS:0] res [bor_pkg::DIV_STAGES];

  // one quotient bit per stage, MSB first; the numerator's only live bit
  // below the starting remainder is inter[0]
  always_comb begin
    res[0] = bor_pkg::div_step(bor_pkg::UNI_BITS'(item.inter >> 1), item.uni,
                               item.inter[0]);
    nxt[0].valid = valid;
    nxt[0].rem   = res[0][bor_pkg::UNI_BITS-1:0];
    nxt[0].uni   = item.uni;
    nxt[0].quo   = bor_pkg::RATIO_BITS'(res[0][bor_pkg::UNI_BITS]);
    nxt[0].empty = item.empty;
    nxt[0].last  = item.last;
    for (int i = 1; i < bor_pkg::DIV_STAGES; i++) begin
      res[i] = bor_pkg::div_step(st[i-1].rem, st[i-1].uni, 1'b0);
      nxt[i].valid = st[i-1].valid;
      nxt[i].rem   = res[i][bor_pkg::UNI_BITS-1:0];
      nxt[i].uni   = st[i-1].uni;
      nxt[i].quo   = {st[i-1].quo[bor_pkg::RATIO_BITS-2:0], res[i][bor_pkg::UNI_BITS]};
      nxt[i].empty = st[i-1].empty;
      nxt[i].last  = st[i-1].last;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < bor_pkg::DIV_STAGES; i++) begin
      if (rst) begin
        st[i] <= '0;
      end else begin
        st[i] <= nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st[LAST_STAGE].valid;
    end
  end

  always_ff @(posedge clk) begin
    overlap_ratio <= st[LAST_STAGE].quo;
    empty_union   <= st[LAST_STAGE].empty;
    last_out      <= st[LAST_STAGE].last;
  end

endmodule
